FILE: rtl/rtpfu_pkg.sv
package rtpfu_pkg;

  // Field widths
  localparam int LengthBits  = 20;
  localparam int MaxPayloadW = 11;
  localparam int SeqW        = 16;
  localparam int TsW         = 32;
  localparam int SsrcW       = 32;
  localparam int CfgIndexW   = 1;
  localparam int CfgDataW    = 32;

  // Default depth of the job queue between front and back
  localparam int QueueDepth = 4;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgSsrc       = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgMaxPayload = 1'b1;

  // Register reset values
  localparam logic [SsrcW-1:0]       SsrcReset       = 32'd12345678;
  localparam logic [MaxPayloadW-1:0] MaxPayloadReset = 11'd1400;
  localparam logic [MaxPayloadW-1:0] MinPayload      = 11'd3;

  // RTP / FU-A header constants
  localparam logic [7:0] RtpByte0  = 8'h80;  // version 2
  localparam logic [7:0] RtpByte1  = 8'h60;  // payload type 96, no marker
  localparam logic [7:0] FuaType   = 8'd28;
  localparam logic [7:0] NriMask   = 8'hE0;
  localparam logic [7:0] TypeMask  = 8'h1F;
  localparam logic [7:0] FuStart   = 8'h80;
  localparam logic [7:0] FuEnd     = 8'h40;

  // Byte positions within one job
  localparam logic [3:0] PosVer    = 4'd0;
  localparam logic [3:0] PosPt     = 4'd1;
  localparam logic [3:0] PosSeqHi  = 4'd2;
  localparam logic [3:0] PosSeqLo  = 4'd3;
  localparam logic [3:0] PosTs3    = 4'd4;
  localparam logic [3:0] PosTs2    = 4'd5;
  localparam logic [3:0] PosTs1    = 4'd6;
  localparam logic [3:0] PosTs0    = 4'd7;
  localparam logic [3:0] PosSsrc3  = 4'd8;
  localparam logic [3:0] PosSsrc2  = 4'd9;
  localparam logic [3:0] PosSsrc1  = 4'd10;
  localparam logic [3:0] PosSsrc0  = 4'd11;
  localparam logic [3:0] PosFuInd  = 4'd12;
  localparam logic [3:0] PosFuHdr  = 4'd13;
  localparam logic [3:0] PosData   = 4'd14;

  typedef struct packed {
    logic [7:0]            payload_byte;
    logic                  first_of_nal;
    logic [LengthBits-1:0] nal_length;
    logic [TsW-1:0]        rtp_timestamp;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
    logic       run_last;
  } out_item_t;

  // One classified input byte, as handed to the back part
  typedef struct packed {
    logic [7:0]      data;
    logic            data_end;
    logic            has_rtp;
    logic            has_fu;
    logic [SeqW-1:0] seq;
    logic [TsW-1:0]  ts;
    logic [7:0]      fu_ind;
    logic [7:0]      fu_hdr;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: rtl/rtp_h264_fua_packetizer.sv
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall   in_item_t: one NAL byte, start flag, length, ts
// out      output     out_valid/out_stall out_item_t: packet byte, packet end, run last
// cfg      input      cfg_valid/cfg_ready index 0 = SSRC, index 1 = max payload
//
// Output runs at one byte per cycle while out_stall_i is low. A data byte gives one
// output byte, a byte that opens a packet gives 13 bytes (RTP header and data) or 15
// bytes (with FU-A indicator and header); the back part's byte sequencer sets these figures.
// Input is stalled only while the job queue between front and back is full.
// Reset clears all unit state, the sequence number and the queue; registers
// return to SSRC 12345678 and max payload 1400. Configuration writes are
// always ready.
module rtp_h264_fua_packetizer #(
  parameter int QDepth = rtpfu_pkg::QueueDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  rtpfu_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output rtpfu_pkg::out_item_t                out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rtpfu_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [rtpfu_pkg::CfgDataW-1:0]      cfg_data_i
);
  import rtpfu_pkg::*;

  logic [SsrcW-1:0]       ssrc_q;
  logic [MaxPayloadW-1:0] max_payload_q;

  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head_job;
  q_status_t q_stat;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ssrc_q        <= SsrcReset;
      max_payload_q <= MaxPayloadReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSsrc:       ssrc_q        <= cfg_data_i[SsrcW-1:0];
        CfgMaxPayload: max_payload_q <= cfg_data_i[MaxPayloadW-1:0];
        default:       ;
      endcase
    end
  end

  rtpfu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_data_i     (in_data_i),
    .q_stat_i      (q_stat),
    .max_payload_i (max_payload_q),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .job_o         (push_job)
  );

  rtpfu_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .stat_o     (q_stat)
  );

  rtpfu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .q_stat_i    (q_stat),
    .ssrc_i      (ssrc_q),
    .out_stall_i (out_stall_i),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // Packet end falls only on a data byte, the last byte of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.packet_end |-> out_data_o.run_last)
    else $error("packet end on a header byte");

  // Bytes of one run leave without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.run_last |=> out_valid_o)
    else $error("gap inside a byte run");

  // Never pop an empty queue, never push a full one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_stat.empty) && !(push && q_stat.full))
    else $error("queue overrun or underrun");

endmodule

FILE: rtl/rtpfu_front.sv
module rtpfu_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  input  rtpfu_pkg::in_item_t                     in_data_i,
  input  rtpfu_pkg::q_status_t                    q_stat_i,
  input  logic [rtpfu_pkg::MaxPayloadW-1:0]       max_payload_i,
  output logic                                    in_stall_o,
  output logic                                    push_o,
  output rtpfu_pkg::job_t                         job_o
);
  import rtpfu_pkg::*;

  logic [SeqW-1:0]        seq_q, seq_d;
  logic [LengthBits-1:0]  nbl_q, nbl_d;
  logic [MaxPayloadW-1:0] cbl_q, cbl_d;
  logic                   frag_q, frag_d;
  logic                   ffp_q, ffp_d;
  logic [7:0]             hdr_q, hdr_d;
  logic [TsW-1:0]         ts_q, ts_d;

  logic                   accept;
  logic [MaxPayloadW-1:0] mp;
  logic [MaxPayloadW-1:0] lim;
  logic                   last_frag;
  logic                   do_data;

  // Hold input while the queue has no room
  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  assign mp        = (max_payload_i < MinPayload) ? MinPayload : max_payload_i;
  assign lim       = mp - MaxPayloadW'(2);
  assign last_frag = (nbl_q <= LengthBits'(lim));

  // Classify the byte and build its job
  always_comb begin
    seq_d   = seq_q;
    nbl_d   = nbl_q;
    cbl_d   = cbl_q;
    frag_d  = frag_q;
    ffp_d   = ffp_q;
    hdr_d   = hdr_q;
    ts_d    = ts_q;
    do_data = 1'b0;
    job_o   = '0;
    job_o.data = in_data_i.payload_byte;

    if (accept) begin
      if (in_data_i.first_of_nal) begin
        frag_d = 1'b0;
        ffp_d  = 1'b0;
        cbl_d  = '0;
        nbl_d  = '0;
        if (in_data_i.nal_length != '0) begin
          ts_d  = in_data_i.rtp_timestamp;
          hdr_d = in_data_i.payload_byte;
          if (in_data_i.nal_length <= LengthBits'(mp)) begin
            // Single NAL unit packet
            job_o.has_rtp = 1'b1;
            job_o.seq     = seq_q;
            job_o.ts      = in_data_i.rtp_timestamp;
            seq_d         = seq_q + SeqW'(1);
            nbl_d         = in_data_i.nal_length;
            cbl_d         = in_data_i.nal_length[MaxPayloadW-1:0];
            do_data       = 1'b1;
          end else begin
            // Drop the NAL header byte, open fragmentation
            frag_d = 1'b1;
            ffp_d  = 1'b1;
            nbl_d  = in_data_i.nal_length - LengthBits'(1);
          end
        end
      end else if (nbl_q != '0) begin
        if (frag_q && cbl_q == '0) begin
          // Open a new FU-A fragment
          job_o.has_rtp = 1'b1;
          job_o.has_fu  = 1'b1;
          job_o.seq     = seq_q;
          job_o.ts      = ts_q;
          job_o.fu_ind  = (hdr_q & NriMask) | FuaType;
          job_o.fu_hdr  = (hdr_q & TypeMask) | (ffp_q ? FuStart : 8'h00) |
                          (last_frag ? FuEnd : 8'h00);
          seq_d         = seq_q + SeqW'(1);
          ffp_d         = 1'b0;
          cbl_d         = last_frag ? nbl_q[MaxPayloadW-1:0] : lim;
        end
        do_data = 1'b1;
      end

      if (do_data) begin
        cbl_d          = cbl_d - MaxPayloadW'(1);
        nbl_d          = nbl_d - LengthBits'(1);
        job_o.data_end = (cbl_d == '0);
        if (nbl_d == '0) begin
          frag_d = 1'b0;
          ffp_d  = 1'b0;
          cbl_d  = '0;
        end
      end
    end
  end

  assign push_o = do_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= '0;
      nbl_q  <= '0;
      cbl_q  <= '0;
      frag_q <= 1'b0;
      ffp_q  <= 1'b0;
      hdr_q  <= '0;
      ts_q   <= '0;
    end else begin
      seq_q  <= seq_d;
      nbl_q  <= nbl_d;
      cbl_q  <= cbl_d;
      frag_q <= frag_d;
      ffp_q  <= ffp_d;
      hdr_q  <= hdr_d;
      ts_q   <= ts_d;
    end
  end

endmodule

FILE: rtl/rtpfu_queue.sv
module rtpfu_queue #(
  parameter int Depth = rtpfu_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rtpfu_pkg::job_t      push_job_i,
  input  logic                 pop_i,
  output rtpfu_pkg::job_t      head_o,
  output rtpfu_pkg::q_status_t stat_o
);
  import rtpfu_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

FILE: rtl/rtpfu_back.sv
module rtpfu_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rtpfu_pkg::job_t                    head_i,
  input  rtpfu_pkg::q_status_t               q_stat_i,
  input  logic [rtpfu_pkg::SsrcW-1:0]        ssrc_i,
  input  logic                               out_stall_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  output rtpfu_pkg::out_item_t               out_data_o
);
  import rtpfu_pkg::*;

  job_t       cur_q;
  logic       busy_q;
  logic [3:0] pos_q;
  logic       out_valid_q;
  out_item_t  out_q;

  logic       load_ok;
  logic       emit;
  logic       at_end;
  logic [3:0] next_pos;
  logic [7:0] cur_byte;

  assign load_ok = !out_valid_q || !out_stall_i;
  assign emit    = busy_q && load_ok;
  assign at_end  = (pos_q == PosData);
  assign pop_o   = load_ok && (!busy_q || at_end) && !q_stat_i.empty;

  // Step to the next byte of the current job
  always_comb begin
    case (pos_q)
      PosSsrc0: next_pos = cur_q.has_fu ? PosFuInd : PosData;
      default:  next_pos = pos_q + 4'd1;
    endcase
  end

  // Select the byte at the current position
  always_comb begin
    case (pos_q)
      PosVer:   cur_byte = RtpByte0;
      PosPt:    cur_byte = RtpByte1;
      PosSeqHi: cur_byte = cur_q.seq[15:8];
      PosSeqLo: cur_byte = cur_q.seq[7:0];
      PosTs3:   cur_byte = cur_q.ts[31:24];
      PosTs2:   cur_byte = cur_q.ts[23:16];
      PosTs1:   cur_byte = cur_q.ts[15:8];
      PosTs0:   cur_byte = cur_q.ts[7:0];
      PosSsrc3: cur_byte = ssrc_i[31:24];
      PosSsrc2: cur_byte = ssrc_i[23:16];
      PosSsrc1: cur_byte = ssrc_i[15:8];
      PosSsrc0: cur_byte = ssrc_i[7:0];
      PosFuInd: cur_byte = cur_q.fu_ind;
      PosFuHdr: cur_byte = cur_q.fu_hdr;
      PosData:  cur_byte = cur_q.data;
      default:  cur_byte = cur_q.data;
    endcase
  end

  // Hold the current job and its byte position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= PosVer;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        pos_q  <= head_i.has_rtp ? PosVer : PosData;
      end else if (emit) begin
        busy_q <= !at_end;
        pos_q  <= next_pos;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_ok) begin
      out_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_byte   <= cur_byte;
      out_q.packet_end <= at_end && cur_q.data_end;
      out_q.run_last   <= at_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: test/rtp_h264_fua_packetizer_tb.sv
module rtp_h264_fua_packetizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtpfu_pkg::*;

  localparam int unsigned SettleCycles = 100;
  localparam int unsigned PhaseItems   = 48;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned MaxShown     = 60;

  typedef enum logic {RowItem, RowReg} row_kind_e;

  // One line of the directed table: an item or a register write
  typedef struct {
    row_kind_e              kind;
    in_item_t               item;
    logic [CfgIndexW-1:0]   reg_idx;
    logic [CfgDataW-1:0]    reg_val;
    int                     typed_n;
    logic [103:0]           typed_bytes;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_item_t            out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  // Packetizer state mirrored by the testbench
  logic [SeqW-1:0]        seq_num;
  logic [LengthBits-1:0]  nal_left;
  logic [MaxPayloadW-1:0] chunk_left;
  bit                     frag_mode;
  bit                     first_frag;
  logic [7:0]             nal_hdr;
  logic [TsW-1:0]         unit_ts;
  logic [SsrcW-1:0]       ssrc_reg;
  logic [MaxPayloadW-1:0] maxpay_reg;

  out_item_t step_q[$];
  out_item_t pkt_stream_q[$];

  // Hand-written expectation for the current item, -1 when none
  int           known_n;
  logic [103:0] known_bytes;

  int unsigned items_taken;
  int unsigned bytes_checked;
  int unsigned mismatches;
  int unsigned reg_writes;
  int unsigned single_pkts;
  int unsigned fu_pkts;
  int unsigned units_cut;
  int unsigned zero_units;
  int unsigned ignored_bytes;
  int unsigned hold_at [2] = '{160, 340};

  rtp_h264_fua_packetizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    mismatches++;
    if (mismatches <= MaxShown) begin
      $display("%0t: packet byte %0d %s: got %0h, expected %0h",
               $time, bytes_checked, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Packetizer prediction
  // ---------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] b, input logic pkt_end);
    out_item_t r;
    r.out_byte   = b;
    r.packet_end = pkt_end;
    r.run_last   = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic put_rtp_hdr(input logic [TsW-1:0] ts);
    put_byte(RtpByte0, 1'b0);
    put_byte(RtpByte1, 1'b0);
    put_byte(seq_num[15:8], 1'b0);
    put_byte(seq_num[7:0], 1'b0);
    for (int i = 3; i >= 0; i--) put_byte(ts[8*i +: 8], 1'b0);
    for (int i = 3; i >= 0; i--) put_byte(ssrc_reg[8*i +: 8], 1'b0);
    seq_num = seq_num + SeqW'(1);
  endtask

  task automatic put_payload(input logic [7:0] b);
    chunk_left = chunk_left - MaxPayloadW'(1);
    nal_left   = nal_left - LengthBits'(1);
    put_byte(b, chunk_left == '0);
    // close the unit on its last byte
    if (nal_left == '0) begin
      frag_mode  = 1'b0;
      first_frag = 1'b0;
      chunk_left = '0;
    end
  endtask

  task automatic packetize(input in_item_t it);
    logic [MaxPayloadW-1:0] eff;
    logic [MaxPayloadW-1:0] lim;
    logic [7:0]             fuh;
    bit                     last;
    step_q.delete();
    eff = (maxpay_reg < MinPayload) ? MinPayload : maxpay_reg;
    if (it.first_of_nal) begin
      // a new unit drops whatever was open
      if (nal_left != '0) units_cut++;
      frag_mode  = 1'b0;
      first_frag = 1'b0;
      chunk_left = '0;
      nal_left   = '0;
      if (it.nal_length == '0) begin
        zero_units++;
      end else begin
        unit_ts = it.rtp_timestamp;
        nal_hdr = it.payload_byte;
        if (it.nal_length <= LengthBits'(eff)) begin
          put_rtp_hdr(it.rtp_timestamp);
          single_pkts++;
          nal_left   = it.nal_length;
          chunk_left = it.nal_length[MaxPayloadW-1:0];
          put_payload(it.payload_byte);
        end else begin
          frag_mode  = 1'b1;
          first_frag = 1'b1;
          nal_left   = it.nal_length - LengthBits'(1);
        end
      end
    end else if (nal_left != '0) begin
      // open the next FU-A fragment
      if (frag_mode && chunk_left == '0) begin
        lim  = eff - MaxPayloadW'(2);
        last = (nal_left <= LengthBits'(lim));
        fuh  = nal_hdr & TypeMask;
        put_rtp_hdr(unit_ts);
        put_byte((nal_hdr & NriMask) | FuaType, 1'b0);
        if (first_frag) fuh = fuh | FuStart;
        if (last) fuh = fuh | FuEnd;
        put_byte(fuh, 1'b0);
        first_frag = 1'b0;
        chunk_left = last ? nal_left[MaxPayloadW-1:0] : lim;
        fu_pkts++;
      end
      put_payload(it.payload_byte);
    end else begin
      ignored_bytes++;
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Accept items and check packet bytes
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      items_taken++;
      packetize(in_data_i);
      if (known_n >= 0) begin
        for (int i = 0; i < known_n; i++) begin
          pkt_stream_q.push_back('{out_byte: known_bytes[103-8*i -: 8],
                                   packet_end: (i == known_n - 1),
                                   run_last: (i == known_n - 1)});
        end
      end else begin
        foreach (step_q[i]) pkt_stream_q.push_back(step_q[i]);
      end
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pkt_stream_q.size() == 0) begin
        report("arrived with nothing expected", out_data_o.out_byte, 8'h00);
      end else begin
        if (out_data_o.out_byte !== pkt_stream_q[0].out_byte)
          report("out_byte", out_data_o.out_byte, pkt_stream_q[0].out_byte);
        if (out_data_o.packet_end !== pkt_stream_q[0].packet_end)
          report("packet_end", 8'(out_data_o.packet_end), 8'(pkt_stream_q[0].packet_end));
        if (out_data_o.run_last !== pkt_stream_q[0].run_last)
          report("run_last", 8'(out_data_o.run_last), 8'(pkt_stream_q[0].run_last));
        void'(pkt_stream_q.pop_front());
      end
      bytes_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random stalls, quiet stretches and long hold-offs
  // ---------------------------------------------------------------------------
  initial begin : out_side
    int unsigned cyc;
    int unsigned run_left;
    int unsigned hold_left;
    int unsigned holds_done;
    int unsigned r;
    bit          stall_on;
    cyc        = 0;
    run_left   = 0;
    hold_left  = 0;
    holds_done = 0;
    stall_on   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      // hold off long enough for the job queue to fill and stall the input
      if (hold_left == 0 && holds_done < 2 && items_taken >= hold_at[holds_done]) begin
        hold_left = LongHold;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (cyc % 1500 < 250) begin
        out_stall_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stall_on = !stall_on;
          r = $urandom_range(0, 99);
          if (!stall_on) run_left = $urandom_range(1, 6);
          else if (r < 80) run_left = $urandom_range(1, 2);
          else if (r < 95) run_left = $urandom_range(3, 8);
          else run_left = $urandom_range(10, 30);
        end
        run_left--;
        out_stall_i <= stall_on;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap(input bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input in_item_t it, input int n_known,
                           input logic [103:0] kb, input bit burst);
    int unsigned gap;
    gap = pick_gap(burst);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    in_data_i   <= it;
    known_n     = n_known;
    known_bytes = kb;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Drop valid and let every expected byte and any silent work drain
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pkt_stream_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (idx == CfgSsrc) ssrc_reg = val;
    else if (idx == CfgMaxPayload) maxpay_reg = val[MaxPayloadW-1:0];
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic dir_row_t item_row(input logic [7:0] b, input logic f,
                                        input logic [LengthBits-1:0] len,
                                        input logic [TsW-1:0] ts, input int n,
                                        input logic [103:0] kb);
    dir_row_t row;
    row.kind                = RowItem;
    row.item.payload_byte   = b;
    row.item.first_of_nal   = f;
    row.item.nal_length     = len;
    row.item.rtp_timestamp  = ts;
    row.reg_idx             = CfgSsrc;
    row.reg_val             = '0;
    row.typed_n             = n;
    row.typed_bytes         = kb;
    return row;
  endfunction

  function automatic dir_row_t reg_row(input logic [CfgIndexW-1:0] idx,
                                       input logic [CfgDataW-1:0] val);
    dir_row_t row;
    row = item_row(8'h00, 1'b0, '0, '0, -1, '0);
    row.kind    = RowReg;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : in_side
    dir_row_t               rows[$];
    logic [MaxPayloadW-1:0] mp_list [NumPhases];
    logic [MaxPayloadW-1:0] mp;
    logic [MaxPayloadW-1:0] eff;
    logic [TsW-1:0]         ts;
    in_item_t               it;
    int unsigned            sent;
    int unsigned            pick;
    int unsigned            len;
    int unsigned            nb;
    int unsigned            lenmax;
    bit                     burst;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgSsrc;
    cfg_data_i  = '0;
    known_n     = -1;
    known_bytes = '0;

    seq_num    = '0;
    nal_left   = '0;
    chunk_left = '0;
    frag_mode  = 1'b0;
    first_frag = 1'b0;
    nal_hdr    = '0;
    unit_ts    = '0;
    ssrc_reg   = SsrcReset;
    maxpay_reg = MaxPayloadReset;

    items_taken   = 0;
    bytes_checked = 0;
    mismatches    = 0;
    reg_writes    = 0;
    single_pkts   = 0;
    fu_pkts       = 0;
    units_cut     = 0;
    zero_units    = 0;
    ignored_bytes = 0;

    mp_list = '{11'd3, 11'd0, 11'd1, 11'd2, 11'd5, 11'd16, 11'd1460, 11'd2047};

    // single-byte unit right after reset: header with seq 0 and the reset SSRC
    rows.push_back(item_row(8'hA5, 1'b1, 20'd1, 32'h0102_0304, 13,
                            {8'h80, 8'h60, 16'h0000, 32'h0102_0304, 32'h00BC_614E, 8'hA5}));
    // byte with no unit open, then a zero-length unit
    rows.push_back(item_row(8'h3C, 1'b0, 20'd0, 32'h0, 0, '0));
    rows.push_back(item_row(8'h77, 1'b1, 20'd0, 32'h0, 0, '0));
    // short unit, left one byte short
    rows.push_back(item_row(8'h00, 1'b1, 20'd3, 32'hFFFF_FFFF, -1, '0));
    rows.push_back(item_row(8'hFF, 1'b0, 20'd0, 32'h0, -1, '0));
    // new unit mid-unit, longest length: header byte alone gives nothing
    rows.push_back(item_row(8'hFF, 1'b1, 20'hFFFFF, 32'h0, 0, '0));
    rows.push_back(item_row(8'h12, 1'b0, 20'd0, 32'h0, -1, '0));
    // unit exactly as long as the payload limit goes out whole
    rows.push_back(item_row(8'h65, 1'b1, 20'd1400, 32'h55AA_55AA, -1, '0));
    rows.push_back(item_row(8'h01, 1'b0, 20'd0, 32'h0, -1, '0));
    // limit below the minimum acts as three: one data byte per fragment
    rows.push_back(reg_row(CfgSsrc, 32'hFFFF_FFFF));
    rows.push_back(reg_row(CfgMaxPayload, 32'd0));
    rows.push_back(item_row(8'h7C, 1'b1, 20'd4, 32'h0, -1, '0));
    rows.push_back(item_row(8'h80, 1'b0, 20'd0, 32'h0, -1, '0));
    rows.push_back(item_row(8'h81, 1'b0, 20'd0, 32'h0, -1, '0));
    rows.push_back(item_row(8'h82, 1'b0, 20'd0, 32'h0, -1, '0));
    // largest register value
    rows.push_back(reg_row(CfgMaxPayload, 32'd2047));
    rows.push_back(reg_row(CfgSsrc, 32'd0));
    rows.push_back(item_row(8'h41, 1'b1, 20'd2047, 32'h0, -1, '0));
    rows.push_back(item_row(8'h42, 1'b0, 20'd0, 32'h0, -1, '0));
    // full fragment sequence: start, middle and end fragments
    rows.push_back(reg_row(CfgMaxPayload, 32'd6));
    rows.push_back(item_row(8'h5C, 1'b1, 20'd10, 32'h89AB_CDEF, -1, '0));
    for (int i = 0; i < 9; i++) begin
      rows.push_back(item_row(8'(8'hC0 + i), 1'b0, 20'd0, 32'h0, -1, '0));
    end

    // hold reset, then release on a falling edge
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // walk the directed table
    foreach (rows[i]) begin
      if (rows[i].kind == RowReg) begin
        wait_idle();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_byte(rows[i].item, rows[i].typed_n, rows[i].typed_bytes, 1'b0);
      end
    end

    // random units, one max payload and one SSRC setting per phase
    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      mp = mp_list[p];
      write_reg(CfgMaxPayload, ($urandom & ~32'h7FF) | CfgDataW'(mp));
      write_reg(CfgSsrc, (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'h0 : $urandom);
      eff    = (mp < MinPayload) ? MinPayload : mp;
      lenmax = eff + eff / 2 + 6;
      if (lenmax > 40) lenmax = 40;
      burst  = (p % 3 == 1);
      sent   = 0;
      while (sent < PhaseItems) begin
        pick = $urandom_range(0, 99);
        it.nal_length    = 20'($urandom);
        it.rtp_timestamp = $urandom;
        it.payload_byte  = 8'($urandom);
        if (pick < 6) begin
          // noise byte, usually with no unit open
          it.first_of_nal = 1'b0;
          send_byte(it, -1, '0, burst);
        end else if (pick < 10) begin
          it.first_of_nal = 1'b1;
          it.nal_length   = '0;
          send_byte(it, -1, '0, burst);
          sent++;
        end else begin
          if (pick < 18) begin
            // huge length, cut short by the next unit
            len = $urandom_range(1, 20'hFFFFF);
            nb  = $urandom_range(1, 6);
          end else begin
            len = $urandom_range(1, lenmax);
            nb  = len;
            if ($urandom_range(0, 19) == 0) nb = $urandom_range(1, len);
          end
          ts = $urandom;
          for (int i = 0; i < nb; i++) begin
            it.payload_byte  = 8'($urandom);
            it.first_of_nal  = (i == 0);
            it.nal_length    = (i == 0) ? LengthBits'(len) : 20'($urandom);
            it.rtp_timestamp = (i == 0) ? ts : $urandom;
            send_byte(it, -1, '0, burst);
          end
          sent += nb;
        end
      end
    end

    wait_idle();
    $display("Run covered %0d NAL bytes, %0d packet bytes and %0d register writes.",
             items_taken, bytes_checked, reg_writes);
    $display("Packets: %0d whole, %0d FU-A; %0d units cut, %0d zero-length, %0d stray bytes.",
             single_pkts, fu_pkts, units_cut, zero_units, ignored_bytes);
    if (mismatches == 0) begin
      $display("rtp_h264_fua_packetizer_tb: PASS");
    end else begin
      $display("rtp_h264_fua_packetizer_tb: FAIL");
    end
    $finish;
  end

  // Bound the run in case the block hangs
  initial begin
    #10_000_000;
    $display("rtp_h264_fua_packetizer_tb: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
rtl/rtpfu_pkg.sv
rtl/rtpfu_front.sv
rtl/rtpfu_queue.sv
rtl/rtpfu_back.sv
rtl/rtp_h264_fua_packetizer.sv
test/rtp_h264_fua_packetizer_tb.sv
